@@ src/gdr_pkg.sv @@
// Shared types, widths and codes of the grid DDA ray caster.
`default_nettype none

package gdr_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int MAP_SIDE_DEF = 64;

   localparam int POS_W      = 22;
   localparam int VEC_W      = 18;
   localparam int SW_W       = 12;
   localparam int COL_W      = 11;
   localparam int CELL_W     = 6;
   localparam int DIST_W     = 24;
   localparam int SAT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // Camera x is a signed Q13.16 value taken from a quotient of up to 29 bits.
   localparam int CAMX_W  = 30;
   localparam int RAY_W   = 33;
   localparam int COORD_W = 10;
   localparam int PNUM_W  = COORD_W + FRAC_BITS + 1;

   localparam int DIV_NUM_W = 41;
   localparam int DIV_DEN_W = 32;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FACE_WEST  = 2'd0,
      FACE_NORTH = 2'd1,
      FACE_EAST  = 2'd2,
      FACE_SOUTH = 2'd3
   } face_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLAYER_X       = 3'd0,
      CSR_PLAYER_Y       = 3'd1,
      CSR_VIEW_DIR_X     = 3'd2,
      CSR_VIEW_DIR_Y     = 3'd3,
      CSR_CAMERA_PLANE_X = 3'd4,
      CSR_CAMERA_PLANE_Y = 3'd5,
      CSR_SCREEN_WIDTH   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_bit;
   } map_cmd_type;

   typedef struct packed {
      logic ready;
      logic rd_bit;
   } map_rsp_type;

   function automatic logic [RAY_W-1:0] ray_mag(input logic signed [RAY_W-1:0] v);
      return v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
   endfunction

endpackage

`default_nettype wire

@@ src/gdr_req_if.sv @@
// Request channel: map writes and ray casts.
`default_nettype none

interface gdr_req_if import gdr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [COL_W-1:0]  column;
   logic [CELL_W-1:0] cell_x;
   logic [CELL_W-1:0] cell_y;
   logic              cell_is_wall;

   modport source (output valid, operation, column, cell_x, cell_y, cell_is_wall,
                   input ready);
   modport sink   (input valid, operation, column, cell_x, cell_y, cell_is_wall,
                   output ready);
endinterface

`default_nettype wire

@@ src/gdr_rsp_if.sv @@
// Response channel: one hit report per ray cast.
`default_nettype none

interface gdr_rsp_if import gdr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] wall_distance;
   logic [1:0]        face;
   logic [CELL_W-1:0] hit_x;
   logic [CELL_W-1:0] hit_y;
   logic              left_map;

   modport source (output valid, wall_distance, face, hit_x, hit_y, left_map,
                   input ready);
   modport sink   (input valid, wall_distance, face, hit_x, hit_y, left_map,
                   output ready);
endinterface

`default_nettype wire

@@ src/gdr_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module gdr_divider import gdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   assign trial = {rem_ff[DIV_DEN_W-1:0], quot_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      den_in   = den_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_NUM_W);
         rem_in   = '0;
         quot_in  = cmd.num;
         den_in   = cmd.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = diff;
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

@@ src/gdr_map.sv @@
// Wall map memory with a clearing sweep after reset.
`default_nettype none

module gdr_map import gdr_pkg::*; #(
   parameter int MAP_SIDE = MAP_SIDE_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  map_cmd_type                             cmd,
   input  logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]    addr,
   output map_rsp_type                             rsp
);

   localparam int DEPTH = MAP_SIDE * MAP_SIDE;
   localparam int AW    = $clog2(DEPTH);

   logic          map_mem [DEPTH];
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          rd_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         map_mem[clr_addr_ff] <= 1'b0;
      end else if (cmd.wr_en) begin
         map_mem[addr] <= cmd.wr_bit;
      end
      if (cmd.rd_en) begin
         rd_bit_ff <= map_mem[addr];
      end
   end

   assign rsp.ready  = !clearing_ff;
   assign rsp.rd_bit = rd_bit_ff;

endmodule

`default_nettype wire

@@ src/grid_dda_raycaster.sv @@
// Top level of the grid DDA ray caster: configuration, sequencer and walk.
//
//  channel   dir  transfer carries
//  req_if    in   map cell write, or ray cast for one screen column
//  rsp_if    out  wall distance, face, hit cell, left-map flag (casts only)
//  csr_*     in   register write, one per cycle with csr_we
//
// A cast runs three serial divisions (camera x, then the x and y deltas), then
// walks the grid, a memory read and then a wall test per cell crossed, and
// ends with a fourth division for the wall distance if a wall is hit.
// After reset the map memory is swept to open cells, during which no request
// is taken. A request is taken while the previous result still waits in the
// output register; a finished cast holds until that register is free.
`default_nettype none

module grid_dda_raycaster import gdr_pkg::*; #(
   parameter int MAP_SIDE = MAP_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gdr_req_if.sink               req_if,
   gdr_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW         = $clog2(MAP_SIDE * MAP_SIDE);
   localparam int STEP_LIMIT = 2 * MAP_SIDE + 2;
   localparam int SCNT_W     = $clog2(STEP_LIMIT + 1);
   localparam int ONE_FX     = 1 << FRAC_BITS;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_CAMDIV = 11'b00000000010,
      S_RAY    = 11'b00000000100,
      S_DXGO   = 11'b00000001000,
      S_DXDIV  = 11'b00000010000,
      S_DYDIV  = 11'b00000100000,
      S_SIDE   = 11'b00001000000,
      S_STEP   = 11'b00010000000,
      S_LOOK   = 11'b00100000000,
      S_PDIV   = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   function automatic logic [SAT_W-1:0] delta_sel(input logic own_zero,
                                                  input logic other_zero,
                                                  input logic [DIV_NUM_W-1:0] q);
      logic [SAT_W-1:0] d;
      if (other_zero) begin
         d = '0;
      end else if (own_zero) begin
         d = SAT_W'(ONE_FX);
      end else if (|q[DIV_NUM_W-1:SAT_W]) begin
         d = '1;
      end else begin
         d = q[SAT_W-1:0];
      end
      return d;
   endfunction

   // Configuration registers.
   logic [POS_W-1:0]        player_x_ff, player_y_ff;
   logic signed [VEC_W-1:0] vdir_x_ff, vdir_y_ff, plane_x_ff, plane_y_ff;
   logic [SW_W-1:0]         swidth_ff;

   state_type state_ff, state_in;

   logic signed [CAMX_W-1:0]  camx_ff, camx_in;
   logic signed [RAY_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [SAT_W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SAT_W-1:0]          sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [SCNT_W-1:0]         steps_ff, steps_in;
   logic [1:0]                face_ff, face_in;
   logic                      p_den_zero_ff, p_den_zero_in;
   logic                      p_neg_ff, p_neg_in;

   logic [DIST_W-1:0] res_dist_ff, res_dist_in;
   logic              res_left_ff, res_left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [1:0]        rsp_face_ff;
   logic [CELL_W-1:0] rsp_hit_x_ff, rsp_hit_y_ff;
   logic              rsp_left_ff;
   logic              rsp_load;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;
   map_cmd_type map_cmd;
   map_rsp_type map_rsp;
   logic [AW-1:0] map_addr;
   logic [AW-1:0] wr_addr, rd_addr;

   logic req_fire;
   logic wr_in_map;

   // Ray direction: view + plane * camera_x, floor-shifted.
   logic signed [VEC_W+CAMX_W-1:0] ray_prod_x, ray_prod_y;

   // Initial side distances.
   logic [FRAC_BITS:0]            dist_x, dist_y;
   logic [FRAC_BITS+SAT_W:0]      side_prod_x, side_prod_y;
   logic [SAT_W:0]                side_top_x, side_top_y;

   // Walk step.
   logic                      take_x;
   logic signed [COORD_W-1:0] nx, ny, ncx, ncy;
   logic [SAT_W:0]            sdx_sum, sdy_sum;
   logic                      n_in_map;

   // Wall distance setup.
   logic                      hit_on_x;
   logic [COORD_W-1:0]        edge_cell;
   logic signed [PNUM_W-1:0]  pnum;
   logic signed [RAY_W-1:0]   pden;
   logic [PNUM_W-1:0]         pnum_mag;

   gdr_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   gdr_map #(.MAP_SIDE(MAP_SIDE)) u_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .addr  (map_addr),
      .rsp   (map_rsp)
   );

   assign req_if.ready = (state_ff == S_IDLE) && map_rsp.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   assign wr_in_map = (COORD_W'(req_if.cell_x) < COORD_W'(MAP_SIDE)) &&
                      (COORD_W'(req_if.cell_y) < COORD_W'(MAP_SIDE));
   assign wr_addr   = AW'(AW'(req_if.cell_y) * AW'(MAP_SIDE)) + AW'(req_if.cell_x);

   assign ray_prod_x = plane_x_ff * camx_ff;
   assign ray_prod_y = plane_y_ff * camx_ff;

   assign dist_x = rx_ff[RAY_W-1] ? {1'b0, player_x_ff[FRAC_BITS-1:0]}
                 : (FRAC_BITS+1)'(ONE_FX) - {1'b0, player_x_ff[FRAC_BITS-1:0]};
   assign dist_y = ry_ff[RAY_W-1] ? {1'b0, player_y_ff[FRAC_BITS-1:0]}
                 : (FRAC_BITS+1)'(ONE_FX) - {1'b0, player_y_ff[FRAC_BITS-1:0]};
   assign side_prod_x = (FRAC_BITS+SAT_W+1)'(dist_x) * (FRAC_BITS+SAT_W+1)'(dx_ff);
   assign side_prod_y = (FRAC_BITS+SAT_W+1)'(dist_y) * (FRAC_BITS+SAT_W+1)'(dy_ff);
   assign side_top_x  = side_prod_x[FRAC_BITS+SAT_W:FRAC_BITS];
   assign side_top_y  = side_prod_y[FRAC_BITS+SAT_W:FRAC_BITS];

   assign take_x  = sdx_ff < sdy_ff;
   assign nx      = rx_ff[RAY_W-1] ? cx_ff - COORD_W'(1) : cx_ff + COORD_W'(1);
   assign ny      = ry_ff[RAY_W-1] ? cy_ff - COORD_W'(1) : cy_ff + COORD_W'(1);
   assign ncx     = take_x ? nx : cx_ff;
   assign ncy     = take_x ? cy_ff : ny;
   assign sdx_sum = {1'b0, sdx_ff} + {1'b0, dx_ff};
   assign sdy_sum = {1'b0, sdy_ff} + {1'b0, dy_ff};
   assign n_in_map = (ncx >= 0) && (ncx < $signed(COORD_W'(MAP_SIDE))) &&
                     (ncy >= 0) && (ncy < $signed(COORD_W'(MAP_SIDE)));
   assign rd_addr  = AW'(AW'(ncy) * AW'(MAP_SIDE)) + AW'(ncx);

   // The near edge of the hit cell, as seen from the player.
   assign hit_on_x  = !face_ff[0];
   assign edge_cell = hit_on_x ? COORD_W'(cx_ff) + COORD_W'(rx_ff[RAY_W-1])
                               : COORD_W'(cy_ff) + COORD_W'(ry_ff[RAY_W-1]);
   assign pnum = $signed({1'b0, edge_cell, FRAC_BITS'(0)})
               - $signed(PNUM_W'(hit_on_x ? player_x_ff : player_y_ff));
   assign pden     = hit_on_x ? rx_ff : ry_ff;
   assign pnum_mag = pnum[PNUM_W-1] ? PNUM_W'(-pnum) : PNUM_W'(pnum);

   always_comb begin
      state_in      = state_ff;
      camx_in       = camx_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sdx_in        = sdx_ff;
      sdy_in        = sdy_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      steps_in      = steps_ff;
      face_in       = face_ff;
      p_den_zero_in = p_den_zero_ff;
      p_neg_in      = p_neg_ff;
      res_dist_in   = res_dist_ff;
      res_left_in   = res_left_ff;
      div_cmd       = '0;
      map_cmd       = '0;
      map_addr      = wr_addr;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_if.operation) == OP_CAST) begin
                  div_cmd.start = 1'b1;
                  div_cmd.num   = DIV_NUM_W'(req_if.column) << (FRAC_BITS + 1);
                  div_cmd.den   = (swidth_ff == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(swidth_ff);
                  state_in      = S_CAMDIV;
               end else begin
                  map_cmd.wr_en  = wr_in_map;
                  map_cmd.wr_bit = req_if.cell_is_wall;
               end
            end
         end
         S_CAMDIV: begin
            if (div_rsp.done) begin
               camx_in  = $signed({1'b0, div_rsp.quot[CAMX_W-2:0]})
                        - $signed(CAMX_W'(ONE_FX));
               state_in = S_RAY;
            end
         end
         S_RAY: begin
            rx_in    = RAY_W'(vdir_x_ff) + RAY_W'(ray_prod_x >>> FRAC_BITS);
            ry_in    = RAY_W'(vdir_y_ff) + RAY_W'(ray_prod_y >>> FRAC_BITS);
            state_in = S_DXGO;
         end
         S_DXGO: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = DIV_NUM_W'(1) << (2 * FRAC_BITS);
            div_cmd.den   = DIV_DEN_W'(ray_mag(rx_ff));
            state_in      = S_DXDIV;
         end
         S_DXDIV: begin
            if (div_rsp.done) begin
               dx_in         = delta_sel(rx_ff == '0, ry_ff == '0, div_rsp.quot);
               div_cmd.start = 1'b1;
               div_cmd.num   = DIV_NUM_W'(1) << (2 * FRAC_BITS);
               div_cmd.den   = DIV_DEN_W'(ray_mag(ry_ff));
               state_in      = S_DYDIV;
            end
         end
         S_DYDIV: begin
            if (div_rsp.done) begin
               dy_in    = delta_sel(ry_ff == '0, rx_ff == '0, div_rsp.quot);
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            sdx_in   = side_top_x[SAT_W] ? '1 : side_top_x[SAT_W-1:0];
            sdy_in   = side_top_y[SAT_W] ? '1 : side_top_y[SAT_W-1:0];
            cx_in    = $signed(COORD_W'(player_x_ff[POS_W-1:FRAC_BITS]));
            cy_in    = $signed(COORD_W'(player_y_ff[POS_W-1:FRAC_BITS]));
            steps_in = '0;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (take_x) begin
               sdx_in  = sdx_sum[SAT_W] ? '1 : sdx_sum[SAT_W-1:0];
               face_in = rx_ff[RAY_W-1] ? FACE_WEST : FACE_EAST;
            end else begin
               sdy_in  = sdy_sum[SAT_W] ? '1 : sdy_sum[SAT_W-1:0];
               face_in = ry_ff[RAY_W-1] ? FACE_NORTH : FACE_SOUTH;
            end
            cx_in    = ncx;
            cy_in    = ncy;
            steps_in = steps_ff + SCNT_W'(1);
            if (n_in_map) begin
               map_cmd.rd_en = 1'b1;
               map_addr      = rd_addr;
               state_in      = S_LOOK;
            end else begin
               res_left_in = 1'b1;
               res_dist_in = '0;
               state_in    = S_DONE;
            end
         end
         S_LOOK: begin
            if (map_rsp.rd_bit) begin
               res_left_in   = 1'b0;
               p_den_zero_in = (pden == '0);
               p_neg_in      = (pnum != '0) && (pnum[PNUM_W-1] != pden[RAY_W-1]);
               div_cmd.start = 1'b1;
               div_cmd.num   = DIV_NUM_W'(pnum_mag) << FRAC_BITS;
               div_cmd.den   = DIV_DEN_W'(ray_mag(pden));
               state_in      = S_PDIV;
            end else if (steps_ff == SCNT_W'(STEP_LIMIT)) begin
               res_left_in = 1'b1;
               res_dist_in = '0;
               state_in    = S_DONE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_PDIV: begin
            if (div_rsp.done) begin
               if (p_den_zero_ff) begin
                  res_dist_in = '1;
               end else if (p_neg_ff) begin
                  res_dist_in = '0;
               end else if (|div_rsp.quot[DIV_NUM_W-1:DIST_W]) begin
                  res_dist_in = '1;
               end else begin
                  res_dist_in = div_rsp.quot[DIST_W-1:0];
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_if.ready) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         player_x_ff  <= '0;
         player_y_ff  <= '0;
         vdir_x_ff    <= VEC_W'(ONE_FX);
         vdir_y_ff    <= '0;
         plane_x_ff   <= '0;
         plane_y_ff   <= VEC_W'(43254);
         swidth_ff    <= SW_W'(640);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_PLAYER_X:       player_x_ff <= csr_wdata[POS_W-1:0];
               CSR_PLAYER_Y:       player_y_ff <= csr_wdata[POS_W-1:0];
               CSR_VIEW_DIR_X:     vdir_x_ff   <= csr_wdata[VEC_W-1:0];
               CSR_VIEW_DIR_Y:     vdir_y_ff   <= csr_wdata[VEC_W-1:0];
               CSR_CAMERA_PLANE_X: plane_x_ff  <= csr_wdata[VEC_W-1:0];
               CSR_CAMERA_PLANE_Y: plane_y_ff  <= csr_wdata[VEC_W-1:0];
               CSR_SCREEN_WIDTH:   swidth_ff   <= csr_wdata[SW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      camx_ff       <= camx_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sdx_ff        <= sdx_in;
      sdy_ff        <= sdy_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      steps_ff      <= steps_in;
      face_ff       <= face_in;
      p_den_zero_ff <= p_den_zero_in;
      p_neg_ff      <= p_neg_in;
      res_dist_ff   <= res_dist_in;
      res_left_ff   <= res_left_in;
      if (rsp_load) begin
         rsp_dist_ff  <= res_left_ff ? '0 : res_dist_ff;
         rsp_face_ff  <= res_left_ff ? 2'(FACE_WEST) : face_ff;
         rsp_hit_x_ff <= res_left_ff ? '0 : cx_ff[CELL_W-1:0];
         rsp_hit_y_ff <= res_left_ff ? '0 : cy_ff[CELL_W-1:0];
         rsp_left_ff  <= res_left_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.wall_distance = rsp_dist_ff;
   assign rsp_if.face          = rsp_face_ff;
   assign rsp_if.hit_x         = rsp_hit_x_ff;
   assign rsp_if.hit_y         = rsp_hit_y_ff;
   assign rsp_if.left_map      = rsp_left_ff;

endmodule

`default_nettype wire

@@ src/gdr_checker.sv @@
// Port-level checks of the ray caster, bound to the top level.
`default_nettype none

module gdr_checker import gdr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_wall_distance,
   input logic [1:0]        rsp_face,
   input logic [CELL_W-1:0] rsp_hit_x,
   input logic [CELL_W-1:0] rsp_hit_y,
   input logic              rsp_left_map
);

   // The map sweep keeps requests out right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken while the map is being cleared");

   a_left_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_left_map) |->
         (rsp_wall_distance == '0 && rsp_face == '0 && rsp_hit_x == '0 && rsp_hit_y == '0))
      else $error("left-map result carries hit data");

   // A cast needs many cycles, so no result can follow a transfer directly.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared right after a request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_wall_distance) && $stable(rsp_face) &&
          $stable(rsp_hit_x) && $stable(rsp_hit_y) && $stable(rsp_left_map)))
      else $error("stalled result changed");

endmodule

bind grid_dda_raycaster gdr_checker u_gdr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_wall_distance (rsp_if.wall_distance),
   .rsp_face          (rsp_if.face),
   .rsp_hit_x         (rsp_if.hit_x),
   .rsp_hit_y         (rsp_if.hit_y),
   .rsp_left_map      (rsp_if.left_map)
);

`default_nettype wire

@@ tb/sv/tb_grid_dda_raycaster.sv @@
// Testbench of the grid DDA ray caster: directed and random map writes and ray casts checked against a predictor.
`timescale 1ns / 100ps

module tb_grid_dda_raycaster;
   import gdr_pkg::*;

   localparam int  CYCLE_LIMIT = 1500000;
   localparam int  WALK_MAX    = 2 * MAP_SIDE_DEF + 2;
   localparam int  DRAIN       = 500;

   typedef struct {
      op_type            op;
      logic [COL_W-1:0]  column;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              wall;
   } ray_req_type;

   typedef struct {
      logic [DIST_W-1:0] wall_dist;
      face_type          face;
      logic [CELL_W-1:0] hit_x;
      logic [CELL_W-1:0] hit_y;
      logic              left;
   } hit_report_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gdr_req_if req ();
   gdr_rsp_if rsp ();

   grid_dda_raycaster u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and the map.
   logic [POS_W-1:0] pos_x, pos_y;
   logic [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
   logic [SW_W-1:0]  columns;
   logic             wall_map [MAP_SIDE_DEF*MAP_SIDE_DEF];

   ray_req_type    pending_reqs[$];
   hit_report_type expected_hits[$];
   ray_req_type    offered;
   int             errors;
   int             hits_seen;
   int             send_gap;
   int             recv_gap;
   int             hold_left;
   bit             hold_done;
   bit             quiet;
   int             cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned ray_delta(longint own, longint other);
      if (other == 0) return 0;
      if (own == 0) return 64'd1 << FRAC_BITS;
      return sat32((64'd1 << (2 * FRAC_BITS)) / abs64(own));
   endfunction

   function automatic logic [DIST_W-1:0] perp_distance(longint num, longint den);
      longint unsigned q;
      if (den == 0) return {DIST_W{1'b1}};
      if (num != 0 && ((num < 0) != (den < 0))) return '0;
      q = (abs64(num) << FRAC_BITS) / abs64(den);
      return (q > 64'hFF_FFFF) ? {DIST_W{1'b1}} : q[DIST_W-1:0];
   endfunction

   function automatic hit_report_type cast_ray(logic [COL_W-1:0] col);
      hit_report_type  r;
      longint          w, camx, rx, ry, edge_pos;
      longint unsigned dx, dy, sdx, sdy, span_x, span_y;
      int              cx, cy, stx, sty;
      bit              hit;
      face_type        face;
      w = (columns == 0) ? 1 : longint'(columns);
      camx = ((longint'(col) << (FRAC_BITS + 1)) / w) - (64'sd1 <<< FRAC_BITS);
      rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * camx) >>> FRAC_BITS);
      ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * camx) >>> FRAC_BITS);
      dx = ray_delta(rx, ry);
      dy = ray_delta(ry, rx);
      cx = int'(pos_x >> FRAC_BITS);
      cy = int'(pos_y >> FRAC_BITS);
      if (rx < 0) begin
         stx = -1;
         span_x = pos_x[FRAC_BITS-1:0];
      end else begin
         stx = 1;
         span_x = (64'd1 << FRAC_BITS) - pos_x[FRAC_BITS-1:0];
      end
      if (ry < 0) begin
         sty = -1;
         span_y = pos_y[FRAC_BITS-1:0];
      end else begin
         sty = 1;
         span_y = (64'd1 << FRAC_BITS) - pos_y[FRAC_BITS-1:0];
      end
      sdx = sat32((span_x * dx) >> FRAC_BITS);
      sdy = sat32((span_y * dy) >> FRAC_BITS);
      hit = 1'b0;
      face = FACE_WEST;
      // The start cell itself is never tested; each step enters a new cell.
      for (int n = 0; n < WALK_MAX; n++) begin
         if (sdx < sdy) begin
            sdx = sat32(sdx + dx);
            cx += stx;
            if (stx < 0) face = FACE_WEST;
            else face = FACE_EAST;
         end else begin
            sdy = sat32(sdy + dy);
            cy += sty;
            if (sty < 0) face = FACE_NORTH;
            else face = FACE_SOUTH;
         end
         if (cx < 0 || cx >= MAP_SIDE_DEF || cy < 0 || cy >= MAP_SIDE_DEF) break;
         if (wall_map[cy*MAP_SIDE_DEF + cx]) begin
            hit = 1'b1;
            break;
         end
      end
      r.wall_dist = '0;
      r.face = FACE_WEST;
      r.hit_x = '0;
      r.hit_y = '0;
      r.left = !hit;
      if (hit) begin
         if (face == FACE_WEST || face == FACE_EAST) begin
            edge_pos = longint'(cx + ((stx < 0) ? 1 : 0)) <<< FRAC_BITS;
            r.wall_dist = perp_distance(edge_pos - longint'(pos_x), rx);
         end else begin
            edge_pos = longint'(cy + ((sty < 0) ? 1 : 0)) <<< FRAC_BITS;
            r.wall_dist = perp_distance(edge_pos - longint'(pos_y), ry);
         end
         r.face = face;
         r.hit_x = cx[CELL_W-1:0];
         r.hit_y = cy[CELL_W-1:0];
      end
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none at all in quiet phases.
   function automatic int draw_gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic ray_req_type make_write(int x, int y, logic wall);
      ray_req_type it;
      it.op = OP_WRITE;
      it.column = COL_W'($urandom_range(0, 2047));
      it.cell_x = CELL_W'(x);
      it.cell_y = CELL_W'(y);
      it.wall = wall;
      return it;
   endfunction

   function automatic ray_req_type make_cast(int col);
      ray_req_type it;
      it.op = OP_CAST;
      it.column = COL_W'(col);
      it.cell_x = CELL_W'($urandom_range(0, 63));
      it.cell_y = CELL_W'($urandom_range(0, 63));
      it.wall = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic ray_req_type make_random_item();
      int w;
      w = (columns == 0) ? 1 : int'(columns);
      if ($urandom_range(0, 99) < 35)
         return make_write($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 80) return make_cast($urandom_range(0, w - 1));
      return make_cast($urandom_range(0, 2047));
   endfunction

   // Request driver: the offered item stays on the bus until its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req.valid && req.ready) begin
            if (offered.op == OP_WRITE)
               wall_map[offered.cell_y*MAP_SIDE_DEF + offered.cell_x] = offered.wall;
            else
               expected_hits.push_back(cast_ray(offered.column));
         end
         if (req.valid && !req.ready) begin
            // Hold the current item.
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            offered = pending_reqs.pop_front();
            req.valid <= 1'b1;
            req.operation <= offered.op;
            req.column <= offered.column;
            req.cell_x <= offered.cell_x;
            req.cell_y <= offered.cell_y;
            req.cell_is_wall <= offered.wall;
            send_gap <= draw_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Response monitor with random stalls and one long hold-off.
   always @(posedge clock) begin
      hit_report_type exp_hit;
      if (reset) begin
         rsp.ready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            hits_seen++;
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result transfer, dist %h", $time, rsp.wall_distance);
               errors++;
            end else begin
               exp_hit = expected_hits.pop_front();
               if (rsp.wall_distance !== exp_hit.wall_dist || rsp.face !== exp_hit.face ||
                   rsp.hit_x !== exp_hit.hit_x || rsp.hit_y !== exp_hit.hit_y ||
                   rsp.left_map !== exp_hit.left) begin
                  $display("%0t: expected dist %h face %0d hit %0d,%0d left %b", $time,
                           exp_hit.wall_dist, exp_hit.face, exp_hit.hit_x, exp_hit.hit_y,
                           exp_hit.left);
                  $display("%0t: actual   dist %h face %0d hit %0d,%0d left %b", $time,
                           rsp.wall_distance, rsp.face, rsp.hit_x, rsp.hit_y, rsp.left_map);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
         end else if (!hold_done && hits_seen >= 100) begin
            // Long stall so that the block fills and refuses requests.
            hold_done <= 1'b1;
            hold_left <= 3000;
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
         end else if (rsp.valid && rsp.ready) begin
            recv_gap <= draw_gap();
            rsp.ready <= (draw_gap() == 0);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req.valid || expected_hits.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PLAYER_X:       pos_x = data[POS_W-1:0];
         CSR_PLAYER_Y:       pos_y = data[POS_W-1:0];
         CSR_VIEW_DIR_X:     dir_x = data[VEC_W-1:0];
         CSR_VIEW_DIR_Y:     dir_y = data[VEC_W-1:0];
         CSR_CAMERA_PLANE_X: plane_x = data[VEC_W-1:0];
         CSR_CAMERA_PLANE_Y: plane_y = data[VEC_W-1:0];
         CSR_SCREEN_WIDTH:   columns = data[SW_W-1:0];
         default:            ;
      endcase
   endtask

   task automatic program_view(int px, int py, int vdx, int vdy, int cpx, int cpy, int sw);
      write_reg(CSR_PLAYER_X, CSR_DATA_W'(px));
      write_reg(CSR_PLAYER_Y, CSR_DATA_W'(py));
      write_reg(CSR_VIEW_DIR_X, CSR_DATA_W'(vdx & 'h3FFFF));
      write_reg(CSR_VIEW_DIR_Y, CSR_DATA_W'(vdy & 'h3FFFF));
      write_reg(CSR_CAMERA_PLANE_X, CSR_DATA_W'(cpx & 'h3FFFF));
      write_reg(CSR_CAMERA_PLANE_Y, CSR_DATA_W'(cpy & 'h3FFFF));
      write_reg(CSR_SCREEN_WIDTH, CSR_DATA_W'(sw));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(int count);
      repeat (count) pending_reqs.push_back(make_random_item());
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = OP_WRITE;
      req.column = '0;
      req.cell_x = '0;
      req.cell_y = '0;
      req.cell_is_wall = 1'b0;
      rsp.ready = 1'b0;
      errors = 0;
      hits_seen = 0;
      hold_done = 1'b0;
      quiet = 1'b0;
      cycles = 0;
      pos_x = '0;
      pos_y = '0;
      dir_x = 18'd65536;
      dir_y = '0;
      plane_x = '0;
      plane_y = 18'd43254;
      columns = 12'd640;
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: casts through an empty map leave it; corner cells; column extremes.
      pending_reqs.push_back(make_cast(0));
      pending_reqs.push_back(make_cast(320));
      pending_reqs.push_back(make_cast(639));
      pending_reqs.push_back(make_cast(2047));
      pending_reqs.push_back(make_write(0, 0, 1'b1));
      pending_reqs.push_back(make_write(63, 63, 1'b1));
      pending_reqs.push_back(make_write(63, 0, 1'b1));
      pending_reqs.push_back(make_write(63, 0, 1'b0));
      pending_reqs.push_back(make_write(5, 0, 1'b1));
      pending_reqs.push_back(make_write(0, 3, 1'b1));
      pending_reqs.push_back(make_cast(0));
      pending_reqs.push_back(make_cast(1));
      pending_reqs.push_back(make_cast(320));
      pending_reqs.push_back(make_cast(1023));
      wait_idle();

      // Walls around the border so that most rays hit something.
      quiet = 1'b1;
      for (int i = 0; i < MAP_SIDE_DEF; i++) begin
         pending_reqs.push_back(make_write(i, 0, 1'b1));
         pending_reqs.push_back(make_write(i, 63, 1'b1));
         pending_reqs.push_back(make_write(0, i, 1'b1));
         pending_reqs.push_back(make_write(63, i, 1'b1));
      end
      wait_idle();
      program_view(32 << 16, 20 << 16, 65536, 0, 0, 43254, 640);
      run_random(40);
      quiet = 1'b0;
      run_random(40);

      // Extremes of every register, the zero width included.
      program_view(0, 0, -131072, 131071, 0, -131072, 0);
      run_random(30);
      program_view('h3FFFFF, 'h3FFFFF, 131071, -131072, 131071, 0, 2048);
      run_random(30);
      // Ray with no x component, then with no y component.
      program_view(30 << 16 | 'h8000, 31 << 16, 0, 65536, 0, 0, 64);
      run_random(30);
      program_view(12 << 16 | 'h1234, 40 << 16 | 'hFFFF, -65536, 0, 0, 0, 1);
      run_random(30);
      program_view(10 << 16, 10 << 16, 0, -65536, -43254, 0, 640);
      run_random(30);

      repeat (4) begin
         program_view($urandom_range(1 << 16, (63 << 16) - 1),
                      $urandom_range(1 << 16, (63 << 16) - 1),
                      $urandom_range(0, 262143), $urandom_range(0, 262143),
                      $urandom_range(0, 262143), $urandom_range(0, 262143),
                      $urandom_range(1, 2048));
         run_random(25);
      end

      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
